// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: design/ldcw_pkg.sv
// Types and constants of the longest distinct-byte window block.
package ldcw_pkg;

	localparam int POS_BITS   = 16;
	localparam int CHAR_BITS  = 8;
	localparam int CHAR_COUNT = 1 << CHAR_BITS;
	localparam int LEN_BITS   = 16;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	typedef logic [POS_BITS-1:0]  pos_t;
	typedef logic [CHAR_BITS-1:0] char_t;
	typedef logic [LEN_BITS-1:0]  len_t;

	// last usable position is one below this
	localparam pos_t POS_LIMIT = '1;

	typedef struct packed {
		char_t ch;
		logic  last;
		logic  fwd;
		pos_t  fwd_pos;
	} step_t;

	typedef struct packed {
		logic  en;
		char_t addr;
		pos_t  data;
	} wr_t;

	typedef struct packed {
		len_t max_length;
		logic overflow;
	} res_t;

endpackage

// File: design/ldcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ldcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/ldcw_scan.sv
// Window update: valid bits, window start, position counter and best length.
module ldcw_scan import ldcw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step_valid,
	input  step_t step,
	input  pos_t  rd_pos,
	output wr_t   wr,
	output res_t  res
);

	logic [CHAR_COUNT-1:0] valid_q;
	pos_t pos_q;
	pos_t ws_q;
	pos_t best_q;
	logic ovf_q;

	logic ignore;
	pos_t last_pos;
	logic hit;
	pos_t ws_new;
	pos_t len;
	pos_t best_new;
	logic sat;

	always_comb begin
		ignore   = ovf_q | (pos_q == POS_LIMIT);
		last_pos = step.fwd ? step.fwd_pos : rd_pos;
		hit      = valid_q[step.ch] && (last_pos >= ws_q);
		ws_new   = hit ? last_pos + pos_t'(1) : ws_q;
		len      = pos_q - ws_new + pos_t'(1);
		if (!ignore && (len > best_q)) begin
			best_new = len;
		end else begin
			best_new = best_q;
		end
		// only a counter wider than the result can saturate
		sat = (POS_BITS > LEN_BITS) && (|(best_new >> LEN_BITS));

		wr.en   = step_valid & ~ignore;
		wr.addr = step.ch;
		wr.data = pos_q;

		res.max_length = sat ? '1 : LEN_BITS'(best_new);
		res.overflow   = ignore | sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			pos_q   <= '0;
			ws_q    <= '0;
			best_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (step_valid) begin
			if (step.last) begin
				valid_q <= '0;
				pos_q   <= '0;
				ws_q    <= '0;
				best_q  <= '0;
				ovf_q   <= 1'b0;
			end else if (ignore) begin
				ovf_q <= 1'b1;
			end else begin
				valid_q[step.ch] <= 1'b1;
				pos_q            <= pos_q + pos_t'(1);
				ws_q             <= ws_new;
				best_q           <= best_new;
			end
		end
	end

endmodule

// File: design/longest_distinct_char_window.sv
// Top level of the longest distinct-byte window block.
//
// Input stream: one string byte per transaction in s_axis_tdata, tlast set on
// the final byte. Output stream: one transaction per string, carrying the
// length of the longest run with no repeated byte (saturated at 65535) and an
// overflow flag in tuser.
// Each byte reads its last-position entry from a 256-entry RAM in the cycle
// it is accepted, then updates the window from the stage register, writing
// the entry back; a back-to-back repeat of the same byte is forwarded around
// the RAM. Throughput is one byte per cycle while input is not held off. The
// result is held in an output register, loaded as the final byte advances.
// Reset clears the window state and the valid bits at once; the RAM contents
// need no clearing. While the receiver stalls, bytes keep flowing until a
// final byte finds the output register still full; input is then held off
// until that result is taken.
`include "assert_macros.svh"

module longest_distinct_char_window import ldcw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] char_byte
	input  logic                  s_axis_tlast,  // end_of_string
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [15:0] max_length
	output logic                  m_axis_tuser   // [0] overflow
);

	logic  valid_s1;
	char_t char_s1;
	logic  last_s1;
	logic  fwd_s1;
	pos_t  fwd_pos_s1;

	logic  out_valid_q;
	len_t  out_len_q;
	logic  out_ovf_q;

	logic  stall;
	logic  advance;
	logic  accept;
	char_t in_char;
	pos_t  rd_pos;
	step_t step;
	wr_t   wr;
	res_t  res;

	assign in_char       = s_axis_tdata[CHAR_BITS-1:0];
	assign stall         = valid_s1 & last_s1 & out_valid_q & ~m_axis_tready;
	assign advance       = valid_s1 & ~stall;
	assign s_axis_tready = ~stall;
	assign accept        = s_axis_tvalid & s_axis_tready;

	assign step.ch      = char_s1;
	assign step.last    = last_s1;
	assign step.fwd     = fwd_s1;
	assign step.fwd_pos = fwd_pos_s1;

	ldcw_ram #(
		.WIDTH(POS_BITS),
		.DEPTH(CHAR_COUNT)
	) u_pos_ram (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.data),
		.re   (accept),
		.raddr(in_char),
		.rdata(rd_pos)
	);

	ldcw_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_valid(advance),
		.step      (step),
		.rd_pos    (rd_pos),
		.wr        (wr),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			// the entry being written this edge is read stale by the RAM
			fwd_s1   <= wr.en & ~last_s1 & (wr.addr == in_char);
		end else if (advance) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1    <= in_char;
			last_s1    <= s_axis_tlast;
			fwd_pos_s1 <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance & last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance & last_s1) begin
			out_len_q <= res.max_length;
			out_ovf_q <= res.overflow;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_len_q);
	assign m_axis_tuser  = out_ovf_q;

	`ASSERT_CLK(a_hold_only_on_full, clk, arst_n,
		!s_axis_tready |-> (valid_s1 && last_s1 && out_valid_q), "input held without cause")
	`ASSERT_CLK(a_result_from_final, clk, arst_n,
		$rose(m_axis_tvalid) |-> $past(valid_s1 && last_s1), "result without final byte")
	`ASSERT_NEVER(a_fwd_needs_item, clk, arst_n,
		fwd_s1 && !valid_s1, "forward flag on empty stage")

endmodule

// File: dv/longest_distinct_char_window_tb.sv
// Self-checking testbench for the longest distinct-byte window block.
`timescale 1ns / 100ps

module longest_distinct_char_window_tb;
	import ldcw_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_BYTES = 440;

	typedef enum {FILL_ANY, FILL_NARROW, FILL_DISTINCT} fill_mode_e;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  s_axis_tlast  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	longest_distinct_char_window dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// predictor state
	pos_t        seen_pos   [CHAR_COUNT];
	bit          seen_valid [CHAR_COUNT];
	pos_t        next_pos;
	pos_t        win_start;
	int unsigned best_len;
	bit          ovf_seen;

	res_t expected_windows[$];

	int tx_gap_max   = 0;
	int rx_stall_max = 0;
	int mismatches   = 0;
	int strings_sent = 0;
	int bytes_sent   = 0;
	int windows_checked  = 0;
	int overflow_windows = 0;
	int idle_cycles  = 0;

	function automatic void clear_window_state();
		foreach (seen_valid[i])
			seen_valid[i] = 1'b0;
		next_pos  = '0;
		win_start = '0;
		best_len  = 0;
		ovf_seen  = 1'b0;
	endfunction

	// Advances the window by one byte; queues the result on the final byte.
	function automatic void predict_window(char_t ch, logic last);
		pos_t        p;
		int unsigned len;
		bit          sat;
		res_t        res;
		if (ovf_seen || next_pos >= POS_LIMIT) begin
			ovf_seen = 1'b1;
		end else begin
			p = next_pos;
			if (seen_valid[ch] && seen_pos[ch] >= win_start)
				win_start = seen_pos[ch] + 1'b1;
			seen_pos[ch]   = p;
			seen_valid[ch] = 1'b1;
			len = int'(p) - int'(win_start) + 1;
			if (len > best_len)
				best_len = len;
			next_pos = p + 1'b1;
		end
		if (last) begin
			sat = best_len > 65535;
			res.max_length = sat ? 16'hFFFF : best_len[15:0];
			res.overflow   = ovf_seen || sat;
			expected_windows = {expected_windows, res};
			clear_window_state();
		end
	endfunction

	// One input transaction; valid stays high into the next call when no gap is drawn.
	task automatic send_byte(char_t ch, logic last);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		predict_window(ch, last);
		bytes_sent++;
		if (last)
			strings_sent++;
	endtask

	task automatic send_string(char_t chars[$]);
		foreach (chars[i])
			send_byte(chars[i], i == chars.size() - 1);
	endtask

	// valid drops first so the byte last sent is not taken again while waiting
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_windows.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_string(int len, fill_mode_e mode);
		char_t base;
		int    alpha;
		char_t ch;
		base  = char_t'($urandom_range(0, 255));
		alpha = $urandom_range(2, 16);
		for (int i = 0; i < len; i++) begin
			case (mode)
			FILL_ANY: begin
				ch = char_t'($urandom_range(0, 255));
			end
			FILL_NARROW: begin
				ch = base + char_t'($urandom_range(0, alpha - 1));
			end
			default: begin
				// mostly fresh bytes, now and then a recent one again
				if ($urandom_range(0, 15) == 0)
					ch = base + char_t'($urandom_range(0, i));
				else
					ch = base + char_t'(i);
			end
			endcase
			send_byte(ch, i == len - 1);
		end
	endtask

	task automatic test_directed_cases();
		char_t s[$];
		tx_gap_max   = 0;
		rx_stall_max = 0;
		s = {8'h00};                      send_string(s);
		s = {8'hFF};                      send_string(s);
		// same byte back to back, then the same single byte in the next string
		s = {8'h61, 8'h61};               send_string(s);
		s = {8'h61};                      send_string(s);
		tx_gap_max   = 3;
		rx_stall_max = 3;
		s = {8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'h62, 8'h62};
		send_string(s);
		// earlier occurrence already left behind the window start
		s = {8'h61, 8'h62, 8'h62, 8'h61}; send_string(s);
		s = {8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80}; send_string(s);
		wait_drained();
	endtask

	task automatic test_full_alphabet();
		char_t s[$];
		tx_gap_max   = 2;
		rx_stall_max = 2;
		s = {};
		for (int i = 0; i < CHAR_COUNT; i++)
			s = {s, char_t'(i)};
		s = {s, 8'h00};
		send_string(s);
		s = {};
		for (int i = 0; i < CHAR_COUNT + 16; i++)
			s = {s, char_t'(255 - (i % CHAR_COUNT))};
		send_string(s);
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		tx_gap_max   = 0;
		rx_stall_max = 8;
		for (int i = 0; i < 30; i++)
			send_random_string($urandom_range(1, 3), FILL_NARROW);
		wait_drained();
	endtask

	task automatic test_random_strings();
		int         start_bytes;
		int         n;
		int         len;
		fill_mode_e mode;
		start_bytes = bytes_sent;
		n = 0;
		while (bytes_sent - start_bytes < RANDOM_BYTES) begin
			if (n % 8 == 0) begin
				tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end
			if (n == 20 || $urandom_range(0, 24) == 0)
				wait_drained();
			len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 100)
			                                    : $urandom_range(1, 24);
			mode = fill_mode_e'($urandom_range(0, 2));
			send_random_string(len, mode);
			n++;
		end
		wait_drained();
	endtask

	// result checker
	always @(posedge clk) begin
		res_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_windows.size() == 0) begin
				$error("unexpected result: max_length %0d overflow %0d",
					m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				exp_res = expected_windows.pop_front();
				windows_checked++;
				if (exp_res.overflow)
					overflow_windows++;
				if (m_axis_tdata !== exp_res.max_length) begin
					$error("max_length: expected %0d, actual %0d",
						exp_res.max_length, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tuser !== exp_res.overflow) begin
					$error("overflow: expected %0d, actual %0d",
						exp_res.overflow, m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	// receiver with random stalls per result
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, rx_stall_max);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", IDLE_LIMIT);
			$display("longest_distinct_char_window regression: fail");
			$finish;
		end
	end

	initial begin
		clear_window_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_full_alphabet();
		test_output_backpressure();
		test_random_strings();

		s_axis_tlast <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d strings, %0d bytes, %0d results checked (%0d with overflow)",
			strings_sent, bytes_sent, windows_checked, overflow_windows);
		$display("incl. single bytes, full 256-byte windows, stale repeats, output stalls");
		if (mismatches == 0 && expected_windows.size() == 0) begin
			$display("longest_distinct_char_window regression: pass");
		end else begin
			if (expected_windows.size() != 0)
				$error("%0d expected results never arrived", expected_windows.size());
			$display("longest_distinct_char_window regression: fail");
		end
		$finish;
	end

endmodule
